FILE: rtl/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg
// Shared types, constants and AES-128 helpers of the private address resolver.
// ----------------------------------------------------------------------------
`default_nettype none
package pra_pkg;

   localparam int LIST_ENTRIES = 16;
   localparam int IDX_W        = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
   localparam int ROUNDS       = 10;

   localparam logic       KIND_LOAD      = 1'b0;
   localparam logic       KIND_RESOLVE   = 1'b1;
   localparam logic [1:0] TYPE_PUBLIC_ID = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [3:0]  entry_index;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic        key_present;
      logic [47:0] identity_address;
      logic [47:0] address;
      logic [1:0]  address_type;
   } req_type;

   typedef struct packed {
      logic        resolved;
      logic [47:0] out_address;
      logic [1:0]  out_address_type;
      logic [47:0] private_address;
      logic [3:0]  matched_index;
   } rsp_type;

   typedef struct packed {
      logic [127:0] key;
      logic [47:0]  identity;
   } entry_type;

   localparam logic [0:255][7:0] SBOX = {
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [0:9][7:0] RCON = {
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [7:0] xt(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte 0 is the most significant byte of the vector
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [0:15][7:0] a;
      logic [0:15][7:0] t;
      logic [0:15][7:0] m;
      logic [7:0]       all;
      a = s;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[i + 4*c] = SBOX[a[i + 4*((c + i) % 4)]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         all          = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         m[4*c]       = t[4*c]   ^ all ^ xt(t[4*c]   ^ t[4*c+1]);
         m[4*c+1]     = t[4*c+1] ^ all ^ xt(t[4*c+1] ^ t[4*c+2]);
         m[4*c+2]     = t[4*c+2] ^ all ^ xt(t[4*c+2] ^ t[4*c+3]);
         m[4*c+3]     = t[4*c+3] ^ all ^ xt(t[4*c+3] ^ t[4*c]);
      end
      return last ? 128'(t) : 128'(m);
   endfunction

   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, tmp, n0, n1, n2, n3;
      w0  = k[127:96];
      w1  = k[95:64];
      w2  = k[63:32];
      w3  = k[31:0];
      tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      n0  = w0 ^ tmp;
      n1  = w1 ^ n0;
      n2  = w2 ^ n1;
      n3  = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/pra_aes.sv
// ----------------------------------------------------------------------------
// pra_aes
// Iterative AES-128 encryptor: one round and one key expansion step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pra_aes
   import pra_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         go,
   input  wire logic [127:0] key,
   input  wire logic [127:0] block,
   output logic              done,
   output logic [127:0]      cipher
);

   logic         run_ff;
   logic [3:0]   round_ff;
   logic [127:0] state_ff;
   logic [127:0] rkey_ff;
   logic         done_ff;
   logic [127:0] rkey_in;
   logic         last;

   assign last    = (round_ff == 4'(ROUNDS));
   assign rkey_in = key_step(rkey_ff, RCON[round_ff - 4'd1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 4'd1;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff   <= 1'b1;
            round_ff <= 4'd1;
            state_ff <= block ^ key;
            rkey_ff  <= key;
         end else if (run_ff) begin
            state_ff <= aes_round(state_ff, last) ^ rkey_in;
            rkey_ff  <= rkey_in;
            round_ff <= round_ff + 4'd1;
            if (last) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign cipher = state_ff;

endmodule
`default_nettype wire

FILE: rtl/pra_list.sv
// ----------------------------------------------------------------------------
// pra_list
// Resolving list store: key and identity memory, valid bits in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none
module pra_list
   import pra_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_index,
   input  wire entry_type        wr_data,
   input  wire logic             wr_valid,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_index,
   output entry_type             rd_data,
   input  wire logic [IDX_W-1:0] chk_index,
   output logic                  chk_valid
);

   entry_type               mem [LIST_ENTRIES];
   entry_type               rd_data_ff;
   logic [LIST_ENTRIES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_index] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_index] <= wr_valid;
      end
   end

   assign rd_data   = rd_data_ff;
   assign chk_valid = valid_ff[chk_index];

endmodule
`default_nettype wire

FILE: rtl/private_address_resolver.sv
// ----------------------------------------------------------------------------
// private_address_resolver
// Resolves private addresses against a list of bonded peer keys.
//
//   channel  ports                     handshake
//   request  req_data                  start high, busy low
//   result   rsp_data                  rsp_valid, one cycle, no back-pressure
//
// A load transaction returns nothing. A resolve walks the slots in order: an
// empty slot is skipped, a valid one goes through a list read, a key schedule
// load and ten rounds in the shared round unit; the walk stops at the first
// match or after the last slot, and then the result is registered.
// Reset clears the valid bits at once; keys are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module private_address_resolver
   import pra_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LOAD, S_CRYPT} state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [47:0]      addr_ff;
   logic [1:0]       atype_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             accept;
   logic             load_wr;
   logic             chk_valid;
   logic             at_last;
   entry_type        entry;
   logic             aes_go;
   logic             aes_done;
   logic [127:0]     cipher;
   entry_type        wr_entry;

   assign accept   = start && !busy;
   assign load_wr  = accept && (req_data.kind == KIND_LOAD)
                     && (int'(req_data.entry_index) < LIST_ENTRIES);
   assign at_last  = (idx_ff == IDX_W'(LIST_ENTRIES - 1));
   assign aes_go   = (state_ff == S_LOAD);
   assign wr_entry = '{key: {req_data.key_high, req_data.key_low},
                       identity: req_data.identity_address};

   pra_list u_list (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (load_wr),
      .wr_index  (IDX_W'(req_data.entry_index)),
      .wr_data   (wr_entry),
      .wr_valid  (req_data.key_present),
      .rd_en     ((state_ff == S_SCAN) && chk_valid),
      .rd_index  (idx_ff),
      .rd_data   (entry),
      .chk_index (idx_ff),
      .chk_valid (chk_valid)
   );

   pra_aes u_aes (
      .clock  (clock),
      .reset  (reset),
      .go     (aes_go),
      .key    (entry.key),
      .block  ({104'd0, addr_ff[47:24]}),
      .done   (aes_done),
      .cipher (cipher)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept && req_data.kind == KIND_RESOLVE) begin
                  addr_ff  <= req_data.address;
                  atype_ff <= req_data.address_type;
                  idx_ff   <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (chk_valid) begin
                  state_ff <= S_LOAD;
               end else if (at_last) begin
                  rsp_ff       <= '{1'b0, addr_ff, atype_ff, 48'd0, 4'd0};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_LOAD: begin
               state_ff <= S_CRYPT;
            end
            S_CRYPT: begin
               if (aes_done) begin
                  if (cipher[23:0] == addr_ff[23:0]) begin
                     rsp_ff       <= '{1'b1, entry.identity, TYPE_PUBLIC_ID, addr_ff,
                                       4'(idx_ff)};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else if (at_last) begin
                     rsp_ff       <= '{1'b0, addr_ff, atype_ff, 48'd0, 4'd0};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_SCAN;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result strobe longer than a cycle");
   a_resolve_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == KIND_RESOLVE) |=> busy)
      else $error("resolve transaction did not start the scan");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy) else $error("result while still scanning");
   a_match_type: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.resolved) |-> (rsp_ff.out_address_type == TYPE_PUBLIC_ID))
      else $error("resolved result with wrong address type");

endmodule
`default_nettype wire

FILE: verif/tb_private_address_resolver.sv
// ----------------------------------------------------------------------------
// tb_private_address_resolver
// Self-checking bench for the private address resolver. It has its own copy of
// the resolving list and its own AES-128, and predicts each resolve
// transaction. A directed table runs first, then a random mix of loads and
// resolves, mostly aimed at addresses that resolve against a live slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_private_address_resolver;
   import pra_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 250;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   private_address_resolver i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // resolving list as the bench sees it
   logic [7:0]   sbox_tab [256];
   logic [127:0] key_list [LIST_ENTRIES];
   logic [47:0]  identity_list [LIST_ENTRIES];
   logic         slot_live [LIST_ENTRIES];
   rsp_type      pending_rsp [$];
   int           err_count = 0;
   int           cycle_count = 0;

   function automatic logic [7:0] gf_dbl(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_dbl(a);
      end
      return p;
   endfunction

   // S-box from the field inverse and the affine map
   task automatic build_sbox();
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = '0;
         for (int y = 1; y < 256; y++) begin
            if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
         end
         sbox_tab[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                       ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   endtask

   // byte 0 is the most significant byte of key and block
   function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                input logic [127:0] blk);
      logic [7:0]   k [16];
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   w [4];
      logic [7:0]   rc;
      logic [7:0]   all, a0, a1, a2, a3;
      logic [127:0] res;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
         k[i] = key[127 - 8*i -: 8];
         s[i] = blk[127 - 8*i -: 8] ^ k[i];
      end
      for (int r = 1; r <= 10; r++) begin
         w[0] = sbox_tab[k[13]] ^ rc;
         w[1] = sbox_tab[k[14]];
         w[2] = sbox_tab[k[15]];
         w[3] = sbox_tab[k[12]];
         for (int i = 0; i < 16; i++) begin
            k[i] = k[i] ^ ((i < 4) ? w[i] : k[i-4]);
         end
         rc = gf_dbl(rc);
         for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
               t[i + 4*c] = sbox_tab[s[i + 4*((c + i) % 4)]];
            end
         end
         if (r != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
               t[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
               t[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
               t[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
      return res;
   endfunction

   function automatic logic [23:0] slot_hash(input int slot, input logic [23:0] prand);
      logic [127:0] ct;
      ct = aes_encrypt(key_list[slot], {104'b0, prand});
      return ct[23:0];
   endfunction

   function automatic rsp_type resolve_address(input logic [47:0] addr,
                                               input logic [1:0] atype);
      rsp_type o;
      o = '{resolved: 1'b0, out_address: addr, out_address_type: atype,
            private_address: '0, matched_index: '0};
      for (int i = 0; i < LIST_ENTRIES; i++) begin
         if (slot_live[i] && slot_hash(i, addr[47:24]) == addr[23:0]) begin
            o = '{resolved: 1'b1, out_address: identity_list[i],
                  out_address_type: TYPE_PUBLIC_ID, private_address: addr,
                  matched_index: 4'(i)};
            break;
         end
      end
      return o;
   endfunction

   // address that hashes to a given slot's key
   function automatic logic [47:0] address_for(input int slot, input logic [23:0] prand);
      return {prand, slot_hash(slot, prand)};
   endfunction

   function automatic req_type load_item(input int slot, input logic [127:0] key,
                                         input logic present, input logic [47:0] ident);
      req_type r;
      r = '0;
      r.kind = KIND_LOAD;
      r.entry_index = 4'(slot);
      {r.key_high, r.key_low} = key;
      r.key_present = present;
      r.identity_address = ident;
      return r;
   endfunction

   function automatic req_type resolve_item(input logic [47:0] addr, input logic [1:0] atype);
      req_type r;
      r = '0;
      r.kind = KIND_RESOLVE;
      r.address = addr;
      r.address_type = atype;
      return r;
   endfunction

   // drives one transaction at the current edge, returns at the accepting edge
   task automatic issue(input req_type r, input logic typed, input rsp_type typed_rsp);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (r.kind == KIND_LOAD) begin
         key_list[r.entry_index]      = {r.key_high, r.key_low};
         identity_list[r.entry_index] = r.identity_address;
         slot_live[r.entry_index]     = r.key_present;
      end else begin
         pending_rsp.push_back(typed ? typed_rsp : resolve_address(r.address, r.address_type));
      end
   endtask

   task automatic maybe_pause(input logic quiet);
      if (!quiet && $urandom_range(99) < 35) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_private_address_resolver: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transaction");
            err_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.resolved !== exp_rsp.resolved) begin
               $error("resolved: exp %0h got %0h", exp_rsp.resolved, rsp_data.resolved);
               err_count++;
            end
            if (rsp_data.out_address !== exp_rsp.out_address) begin
               $error("out_address: exp %0h got %0h", exp_rsp.out_address,
                      rsp_data.out_address);
               err_count++;
            end
            if (rsp_data.out_address_type !== exp_rsp.out_address_type) begin
               $error("out_address_type: exp %0h got %0h", exp_rsp.out_address_type,
                      rsp_data.out_address_type);
               err_count++;
            end
            if (rsp_data.private_address !== exp_rsp.private_address) begin
               $error("private_address: exp %0h got %0h", exp_rsp.private_address,
                      rsp_data.private_address);
               err_count++;
            end
            if (rsp_data.matched_index !== exp_rsp.matched_index) begin
               $error("matched_index: exp %0h got %0h", exp_rsp.matched_index,
                      rsp_data.matched_index);
               err_count++;
            end
         end
      end
   end

   typedef struct {
      req_type     r;
      int          match_slot;   // -1: address used as given
      logic        typed;
      rsp_type     e;
   } stim_row_type;

   localparam logic [127:0] KEY_A = 128'h0f1e2d3c4b5a69788796a5b4c3d2e1f0;
   localparam logic [127:0] ONES  = '1;
   localparam logic [47:0]  A_ONES = '1;

   stim_row_type dir_table [] = '{
      // empty list: everything passes through
      '{resolve_item(48'h0, 2'd0), -1, 1'b1, '{1'b0, 48'h0, 2'd0, 48'h0, 4'h0}},
      '{resolve_item(A_ONES, 2'd3), -1, 1'b1, '{1'b0, A_ONES, 2'd3, 48'h0, 4'h0}},
      '{load_item(0, 128'h0, 1'b1, 48'h1), -1, 1'b0, '0},
      '{load_item(15, ONES, 1'b1, A_ONES), -1, 1'b0, '0},
      '{load_item(7, KEY_A, 1'b0, 48'h777777777777), -1, 1'b0, '0},
      '{resolve_item(48'h0, 2'd1), 0, 1'b0, '0},
      '{resolve_item(A_ONES, 2'd1), 0, 1'b0, '0},
      '{resolve_item(48'h0, 2'd1), 15, 1'b0, '0},
      '{resolve_item(A_ONES, 2'd0), 15, 1'b0, '0},
      // slot loaded without key must not resolve
      '{resolve_item(48'h5a5a5a000000, 2'd1), 7, 1'b0, '0},
      '{resolve_item(48'h123456abcdef, 2'd2), -1, 1'b0, '0},
      '{resolve_item(48'hfedcba654321, 2'd3), -1, 1'b0, '0},
      // duplicate key in a lower slot: lowest slot wins
      '{load_item(3, ONES, 1'b1, 48'h123456789abc), -1, 1'b0, '0},
      '{resolve_item(48'h800001000000, 2'd1), 15, 1'b0, '0},
      '{load_item(3, ONES, 1'b0, 48'h123456789abc), -1, 1'b0, '0},
      '{resolve_item(48'h800001000000, 2'd1), 15, 1'b0, '0},
      '{load_item(7, KEY_A, 1'b1, 48'h777777777777), -1, 1'b0, '0},
      '{resolve_item(48'h5a5a5a000000, 2'd1), 7, 1'b0, '0},
      '{load_item(0, KEY_A, 1'b1, 48'h000000000002), -1, 1'b0, '0},
      '{resolve_item(48'h5a5a5a000000, 2'd1), 7, 1'b0, '0}
   };

   initial begin
      req_type r;
      int      slot;
      int      live [$];
      build_sbox();
      for (int i = 0; i < LIST_ENTRIES; i++) slot_live[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[n]) begin
         r = dir_table[n].r;
         if (dir_table[n].match_slot >= 0)
            r.address = address_for(dir_table[n].match_slot, r.address[47:24]);
         maybe_pause(1'b0);
         issue(r, dir_table[n].typed, dir_table[n].e);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // hold off until the block has drained once
         if (n == 700) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         maybe_pause(n >= 400 && n < 600);
         r.kind             = 1'($urandom_range(99) >= 25);
         r.entry_index      = 4'($urandom);
         {r.key_high, r.key_low} = {$urandom, $urandom, $urandom, $urandom};
         r.key_present      = 1'($urandom_range(99) >= 20);
         r.identity_address = {16'($urandom), 32'($urandom)};
         r.address          = {16'($urandom), 32'($urandom)};
         r.address_type     = 2'($urandom);
         live.delete();
         for (int i = 0; i < LIST_ENTRIES; i++) if (slot_live[i]) live.push_back(i);
         if (r.kind == KIND_LOAD && live.size() != 0 && $urandom_range(99) < 20)
            {r.key_high, r.key_low} = key_list[live[$urandom_range(live.size() - 1)]];
         if (r.kind == KIND_RESOLVE && live.size() != 0 && $urandom_range(99) < 70) begin
            slot = live[$urandom_range(live.size() - 1)];
            r.address = address_for(slot, r.address[47:24]);
         end
         issue(r, 1'b0, '0);
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_private_address_resolver: PASS");
      end else begin
         $display("tb_private_address_resolver: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/pra_pkg.sv
rtl/pra_aes.sv
rtl/pra_list.sv
rtl/private_address_resolver.sv
verif/tb_private_address_resolver.sv
